// File: hdl/framed_message_receiver_top_assert.svh
// Assertion macros shared by the framed message receiver RTL
`ifndef FRAMED_MESSAGE_RECEIVER_TOP_ASSERT_SVH
`define FRAMED_MESSAGE_RECEIVER_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define FMR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define FMR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/fmr_pkg.sv
// Types, codes and helpers for the framed message receiver
package fmr_pkg;

    localparam int OP_W     = 2;
    localparam int BYTE_W   = 8;
    localparam int IDX_W    = 5;
    localparam int STATE_W  = 3;
    localparam int LEN_W    = 6;
    localparam int IDLE_W   = 17;
    localparam int TMO_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};

    // operation codes
    localparam logic [OP_W-1:0] OP_BYTE    = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
    localparam logic [OP_W-1:0] OP_READ    = 2'd2;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd3;

    // receiver phases
    localparam logic [STATE_W-1:0] PH_HUNT     = 3'd0;
    localparam logic [STATE_W-1:0] PH_PAYLOAD  = 3'd1;
    localparam logic [STATE_W-1:0] PH_CHECKSUM = 3'd2;
    localparam logic [STATE_W-1:0] PH_READY    = 3'd3;
    localparam logic [STATE_W-1:0] PH_LOST     = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_CHAR     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEP_CHAR      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_CHAR_A    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_CHAR_B    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RX_TIMEOUT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LINK_TIMEOUT  = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] data_byte;
        logic [IDX_W-1:0]  read_index;
    } item_t;

    typedef struct packed {
        logic [STATE_W-1:0] rx_state;
        logic               message_ready;
        logic [LEN_W-1:0]   message_length;
        logic [BYTE_W-1:0]  read_data;
        logic               byte_rejected;
        logic               checksum_failed;
        logic               frame_timed_out;
        logic               link_lost_event;
    } result_t;

    // ASCII hex digit to nibble; anything else counts as zero
    function automatic logic [3:0] hex_value(input logic [BYTE_W-1:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c[3:0];
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            v = 4'(c[3:0] + 4'd9);
        end
        return v;
    endfunction

endpackage

// File: hdl/fmr_ram.sv
// Generic single-write, single-read RAM with registered read data
module fmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/framed_message_receiver_top.sv
// Framed message receiver: frame parser, payload RAM and result pipeline
//
// Takes one transaction per clock while the input is not stalled (byte, tick, read
// or release) and returns one result per transaction, through the payload RAM read
// stage and then the output register. Frame state (phase, count, XOR,
// received checksum, idle ticks) updates in the acceptance cycle, so items can
// follow back to back; the payload bytes live in a MAX_PAYLOAD-entry RAM with a
// registered read. The input stalls only while both the RAM read stage and the
// output register hold results and the output is stalled. The payload RAM needs
// no clearing after reset: only entries below the stored count are ever returned.
// Configuration writes are always ready.
`include "framed_message_receiver_top_assert.svh"

module framed_message_receiver_top #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  fmr_pkg::item_t              item,
    output logic                        result_valid,
    input  logic                        result_stall,
    output fmr_pkg::result_t            result,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [fmr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fmr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fmr_pkg::*;

    localparam int CW     = $clog2(MAX_PAYLOAD + 1);
    localparam int AW     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CMP_W  = (CW > IDX_W) ? CW : IDX_W;
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_PAYLOAD);

    // configuration
    logic [BYTE_W-1:0] sync_char_reg, sep_char_reg, end_a_reg, end_b_reg;
    logic [TMO_W-1:0]  rx_tmo_reg, link_tmo_reg;

    // frame state
    logic [STATE_W-1:0] phase_reg, phase_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [BYTE_W-1:0]  xor_reg, xor_next;
    logic [BYTE_W-1:0]  cksum_reg, cksum_next;
    logic [IDLE_W-1:0]  idle_reg, idle_next;
    logic               rej, ckf, tmo, lost;

    // pipeline
    logic               item_accept;
    logic               s1_valid_reg;
    logic               s1_adv;
    logic               s1_rd_sel_reg;
    result_t            s1_res_reg;
    result_t            s1_out;
    result_t            res_now;
    logic               out_valid_reg;
    result_t            out_reg;

    // RAM
    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic               ram_rd_en;
    logic               rd_in_range;
    logic [BYTE_W-1:0]  ram_rd_data;
    logic               is_end;

    assign cfg_ready    = 1'b1;
    assign s1_adv       = !out_valid_reg || !result_stall;
    assign item_stall   = s1_valid_reg && !s1_adv;
    assign item_accept  = item_valid && !item_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_char_reg <= 8'd36;
            sep_char_reg  <= 8'd42;
            end_a_reg     <= 8'd13;
            end_b_reg     <= 8'd10;
            rx_tmo_reg    <= 16'd500;
            link_tmo_reg  <= 16'd5000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SYNC_CHAR:    sync_char_reg <= cfg_data[BYTE_W-1:0];
                REG_SEP_CHAR:     sep_char_reg  <= cfg_data[BYTE_W-1:0];
                REG_END_CHAR_A:   end_a_reg     <= cfg_data[BYTE_W-1:0];
                REG_END_CHAR_B:   end_b_reg     <= cfg_data[BYTE_W-1:0];
                REG_RX_TIMEOUT:   rx_tmo_reg    <= cfg_data[TMO_W-1:0];
                REG_LINK_TIMEOUT: link_tmo_reg  <= cfg_data[TMO_W-1:0];
                default: ;
            endcase
        end
    end

    assign is_end = (item.data_byte == end_a_reg) || (item.data_byte == end_b_reg);

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        xor_next   = xor_reg;
        cksum_next = cksum_reg;
        idle_next  = idle_reg;
        rej  = 1'b0;
        ckf  = 1'b0;
        tmo  = 1'b0;
        lost = 1'b0;
        ram_wr_en = 1'b0;
        case (item.op)
            OP_BYTE:
            begin
                idle_next = '0;
                // leaving link lost drops the frame, then the byte is seen as in hunt
                if (phase_reg == PH_LOST)
                begin
                    phase_next = PH_HUNT;
                    count_next = '0;
                    xor_next   = '0;
                    cksum_next = '0;
                end
                case (phase_next)
                    PH_READY:
                    begin
                        rej = 1'b1;
                    end
                    PH_HUNT:
                    begin
                        if (item.data_byte == sync_char_reg)
                        begin
                            phase_next = PH_PAYLOAD;
                            count_next = '0;
                            xor_next   = '0;
                            cksum_next = '0;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        if (item.data_byte == sync_char_reg)
                        begin
                            count_next = '0;
                            xor_next   = '0;
                            cksum_next = '0;
                        end
                        else if (item.data_byte == sep_char_reg)
                        begin
                            phase_next = PH_CHECKSUM;
                        end
                        else if (is_end)
                        begin
                            phase_next = PH_READY;
                        end
                        else if (count_reg < MAX_COUNT)
                        begin
                            ram_wr_en  = 1'b1;
                            count_next = CW'(count_reg + 1'b1);
                            xor_next   = xor_reg ^ item.data_byte;
                        end
                        else
                        begin
                            phase_next = PH_HUNT;
                        end
                    end
                    default:
                    begin
                        if (is_end)
                        begin
                            if (cksum_reg == xor_reg)
                            begin
                                phase_next = PH_READY;
                            end
                            else
                            begin
                                phase_next = PH_HUNT;
                                ckf = 1'b1;
                            end
                        end
                        else
                        begin
                            cksum_next = {cksum_reg[3:0], hex_value(item.data_byte)};
                        end
                    end
                endcase
            end
            OP_TICK:
            begin
                if (idle_reg != IDLE_MAX)
                begin
                    idle_next = IDLE_W'(idle_reg + 1'b1);
                end
                if ((phase_reg == PH_PAYLOAD || phase_reg == PH_CHECKSUM) &&
                    idle_next > {1'b0, rx_tmo_reg})
                begin
                    phase_next = PH_HUNT;
                    tmo = 1'b1;
                end
                else if (phase_reg != PH_LOST && idle_next > {1'b0, link_tmo_reg})
                begin
                    phase_next = PH_LOST;
                    lost = 1'b1;
                end
            end
            OP_RELEASE:
            begin
                count_next = '0;
                phase_next = PH_HUNT;
            end
            default: ;
        endcase
    end

    assign rd_in_range = (CMP_W'(item.read_index) < CMP_W'(count_reg)) &&
                         (CMP_W'(item.read_index) < CMP_W'(MAX_COUNT));
    assign ram_rd_en   = item_accept && (item.op == OP_READ) && rd_in_range;
    assign ram_wr_addr = AW'(count_reg);

    fmr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PAYLOAD)
    ) u_payload_ram (
        .clk     (clk),
        .wr_en   (item_accept && ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (item.data_byte),
        .rd_en   (ram_rd_en),
        .rd_addr (AW'(item.read_index)),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            count_reg <= '0;
            xor_reg   <= '0;
            cksum_reg <= '0;
            idle_reg  <= '0;
        end
        else if (item_accept)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            xor_reg   <= xor_next;
            cksum_reg <= cksum_next;
            idle_reg  <= idle_next;
        end
    end

    always_comb
    begin
        res_now                 = '0;
        res_now.rx_state        = phase_next;
        res_now.message_ready   = (phase_next == PH_READY);
        res_now.message_length  = LEN_W'(count_next);
        res_now.byte_rejected   = rej;
        res_now.checksum_failed = ckf;
        res_now.frame_timed_out = tmo;
        res_now.link_lost_event = lost;
    end

    // stage 1 waits for the RAM read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            s1_res_reg    <= res_now;
            s1_rd_sel_reg <= ram_rd_en;
        end
    end

    always_comb
    begin
        s1_out           = s1_res_reg;
        s1_out.read_data = s1_rd_sel_reg ? ram_rd_data : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_valid_reg && s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_adv)
        begin
            out_reg <= s1_out;
        end
    end

    `FMR_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= MAX_COUNT,
        "payload count above bound")
    `FMR_ASSERT_NOW(a_write_in_payload, clk, rst_n, item_accept && ram_wr_en,
        phase_reg == PH_PAYLOAD && count_reg < MAX_COUNT,
        "payload RAM written outside payload phase")
    `FMR_ASSERT_NEXT(a_release_clears, clk, rst_n, item_accept && item.op == OP_RELEASE,
        count_reg == '0 && phase_reg == PH_HUNT, "release did not clear frame")
    `FMR_ASSERT_NEXT(a_byte_clears_idle, clk, rst_n, item_accept && item.op == OP_BYTE,
        idle_reg == '0, "byte did not clear idle count")

endmodule

// File: verif/tb.sv
// Self-checking testbench for the framed message receiver
`timescale 1ns / 100ps

module tb;
    import fmr_pkg::*;

    localparam int MAX_PAYLOAD = 32;
    localparam int STUCK_LIMIT = 2000;

    // Tracks the receiver's frame state and queues the result each transaction should produce
    class frame_tracker;
        logic [BYTE_W-1:0] sync_c;
        logic [BYTE_W-1:0] sep_c;
        logic [BYTE_W-1:0] end_a;
        logic [BYTE_W-1:0] end_b;
        logic [TMO_W-1:0]  rx_limit;
        logic [TMO_W-1:0]  link_limit;
        logic [STATE_W-1:0] cur_phase;
        logic [BYTE_W-1:0] frame_bytes [MAX_PAYLOAD];
        logic [LEN_W-1:0]  byte_count;
        logic [BYTE_W-1:0] running_xor;
        logic [BYTE_W-1:0] sent_sum;
        logic [IDLE_W-1:0] quiet_ticks;
        result_t           due[$];
        int                mismatches;

        function new();
            sync_c = 8'h24;
            sep_c = 8'h2A;
            end_a = 8'h0D;
            end_b = 8'h0A;
            rx_limit = 16'd500;
            link_limit = 16'd5000;
            cur_phase = PH_HUNT;
            quiet_ticks = '0;
            mismatches = 0;
            start_over();
        endfunction

        function void start_over();
            byte_count = '0;
            running_xor = '0;
            sent_sum = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_SYNC_CHAR:    sync_c = val[7:0];
                REG_SEP_CHAR:     sep_c = val[7:0];
                REG_END_CHAR_A:   end_a = val[7:0];
                REG_END_CHAR_B:   end_b = val[7:0];
                REG_RX_TIMEOUT:   rx_limit = val;
                REG_LINK_TIMEOUT: link_limit = val;
                default:          ;
            endcase
        endfunction

        function logic [3:0] digit_value(logic [BYTE_W-1:0] c);
            if (c >= 8'h30 && c <= 8'h39)
            begin
                return 4'(c - 8'h30);
            end
            if (c >= 8'h41 && c <= 8'h46)
            begin
                return 4'(c - 8'h37);
            end
            if (c >= 8'h61 && c <= 8'h66)
            begin
                return 4'(c - 8'h57);
            end
            return 4'd0;
        endfunction

        function void note_item(item_t it);
            result_t r;
            logic [BYTE_W-1:0] c;
            logic ends;
            r = '0;
            c = it.data_byte;
            ends = (c == end_a) || (c == end_b);
            case (it.op)
                OP_BYTE:
                begin
                    quiet_ticks = '0;
                    if (cur_phase == PH_LOST)
                    begin
                        start_over();
                        cur_phase = PH_HUNT;
                    end
                    if (cur_phase == PH_READY)
                    begin
                        r.byte_rejected = 1'b1;
                    end
                    else if (cur_phase == PH_HUNT)
                    begin
                        if (c == sync_c)
                        begin
                            start_over();
                            cur_phase = PH_PAYLOAD;
                        end
                    end
                    else if (cur_phase == PH_PAYLOAD)
                    begin
                        // sync beats separator beats end byte beats storing
                        if (c == sync_c)
                        begin
                            start_over();
                        end
                        else if (c == sep_c)
                        begin
                            cur_phase = PH_CHECKSUM;
                        end
                        else if (ends)
                        begin
                            cur_phase = PH_READY;
                        end
                        else if (byte_count < MAX_PAYLOAD)
                        begin
                            frame_bytes[byte_count] = c;
                            byte_count++;
                            running_xor ^= c;
                        end
                        else
                        begin
                            cur_phase = PH_HUNT;
                        end
                    end
                    else if (ends)
                    begin
                        if (sent_sum == running_xor)
                        begin
                            cur_phase = PH_READY;
                        end
                        else
                        begin
                            cur_phase = PH_HUNT;
                            r.checksum_failed = 1'b1;
                        end
                    end
                    else
                    begin
                        sent_sum = {sent_sum[3:0], digit_value(c)};
                    end
                end
                OP_TICK:
                begin
                    if (quiet_ticks != IDLE_MAX)
                    begin
                        quiet_ticks++;
                    end
                    if ((cur_phase == PH_PAYLOAD || cur_phase == PH_CHECKSUM) &&
                        quiet_ticks > {1'b0, rx_limit})
                    begin
                        cur_phase = PH_HUNT;
                        r.frame_timed_out = 1'b1;
                    end
                    else if (cur_phase != PH_LOST && quiet_ticks > {1'b0, link_limit})
                    begin
                        cur_phase = PH_LOST;
                        r.link_lost_event = 1'b1;
                    end
                end
                OP_READ:
                begin
                    if (it.read_index < byte_count && it.read_index < MAX_PAYLOAD)
                    begin
                        r.read_data = frame_bytes[it.read_index];
                    end
                end
                OP_RELEASE:
                begin
                    byte_count = '0;
                    cur_phase = PH_HUNT;
                end
                default: ;
            endcase
            r.rx_state = cur_phase;
            r.message_ready = (cur_phase == PH_READY);
            r.message_length = byte_count;
            due.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                mismatches++;
                $error("%s: expected %0d, got %0d", name, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (due.size() == 0)
            begin
                mismatches++;
                $error("result with nothing expected: %p", got);
                return;
            end
            want = due.pop_front();
            compare_field("rx_state", 8'(want.rx_state), 8'(got.rx_state));
            compare_field("message_ready", 8'(want.message_ready), 8'(got.message_ready));
            compare_field("message_length", 8'(want.message_length), 8'(got.message_length));
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("byte_rejected", 8'(want.byte_rejected), 8'(got.byte_rejected));
            compare_field("checksum_failed", 8'(want.checksum_failed), 8'(got.checksum_failed));
            compare_field("frame_timed_out", 8'(want.frame_timed_out), 8'(got.frame_timed_out));
            compare_field("link_lost_event", 8'(want.link_lost_event), 8'(got.link_lost_event));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    item_t rx_item;
    logic result_valid;
    logic result_stall;
    result_t rx_result;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    frame_tracker tracker;
    item_t burst[$];
    bit idling_on;
    int hold_off;
    int stuck_cycles;

    framed_message_receiver_top #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(rx_item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(rx_result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // result side: random stalls, plus a counted hold-off when requested
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off > 0)
            begin
                hold_off--;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= idling_on && ($urandom_range(99) < 18);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            tracker.check_result(rx_result);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
            begin
                stuck_cycles <= 0;
            end
            else if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
            else
            begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    function automatic item_t make_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] b,
                                        input logic [IDX_W-1:0] idx);
        item_t it;
        it.op = op;
        it.data_byte = b;
        it.read_index = idx;
        return it;
    endfunction

    function automatic item_t byte_item(input logic [BYTE_W-1:0] b);
        return make_item(OP_BYTE, b, IDX_W'($urandom));
    endfunction

    function automatic item_t tick_item();
        return make_item(OP_TICK, BYTE_W'($urandom), IDX_W'($urandom));
    endfunction

    function automatic item_t read_item(input logic [IDX_W-1:0] idx);
        return make_item(OP_READ, BYTE_W'($urandom), idx);
    endfunction

    function automatic item_t release_item();
        return make_item(OP_RELEASE, BYTE_W'($urandom), IDX_W'($urandom));
    endfunction

    // payload byte that is none of the framing characters
    function automatic logic [BYTE_W-1:0] plain_byte();
        logic [BYTE_W-1:0] b;
        do
        begin
            b = BYTE_W'($urandom_range(255));
        end
        while (b == tracker.sync_c || b == tracker.sep_c ||
               b == tracker.end_a || b == tracker.end_b);
        return b;
    endfunction

    function automatic item_t hex_digit(input logic [3:0] n);
        logic [BYTE_W-1:0] c;
        if (n < 4'd10)
        begin
            c = 8'h30 + 8'(n);
        end
        else
        begin
            c = (($urandom_range(1) != 0) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
        end
        return byte_item(c);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_char(input logic [BYTE_W-1:0] usual);
        return ($urandom_range(1) != 0) ? usual : BYTE_W'($urandom_range(255));
    endfunction

    // one chunk of traffic: mostly complete frames, some noise and tick runs
    function automatic void build_burst();
        int kind;
        int len;
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        kind = $urandom_range(99);
        if (kind < 12)
        begin
            repeat ($urandom_range(1, 6))
            begin
                burst.push_back(make_item(OP_W'($urandom), BYTE_W'($urandom), IDX_W'($urandom)));
            end
        end
        else if (kind < 20)
        begin
            repeat ($urandom_range(1, 12))
            begin
                burst.push_back(tick_item());
            end
        end
        else
        begin
            burst.push_back(byte_item(tracker.sync_c));
            kind = $urandom_range(99);
            len = (kind < 5) ? MAX_PAYLOAD + 1 :
                  (kind < 12) ? $urandom_range(20, MAX_PAYLOAD) : $urandom_range(0, 8);
            sum = '0;
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(99) < 3)
                begin
                    burst.push_back(byte_item(tracker.sync_c));
                    sum = '0;
                end
                if ($urandom_range(99) < 4)
                begin
                    burst.push_back(tick_item());
                end
                b = plain_byte();
                burst.push_back(byte_item(b));
                sum ^= b;
            end
            if ($urandom_range(99) >= 35)
            begin
                burst.push_back(byte_item(tracker.sep_c));
                if ($urandom_range(99) < 20)
                begin
                    sum = BYTE_W'($urandom);
                end
                kind = $urandom_range(99);
                if (kind < 8)
                begin
                    burst.push_back(hex_digit(sum[3:0]));
                end
                else
                begin
                    // a leading extra digit, or a sync counted as a digit, gets shifted out
                    if (kind < 16)
                    begin
                        burst.push_back(hex_digit(4'($urandom)));
                    end
                    else if (kind < 22)
                    begin
                        burst.push_back(byte_item(tracker.sync_c));
                    end
                    burst.push_back(hex_digit(sum[7:4]));
                    burst.push_back(hex_digit(sum[3:0]));
                end
            end
            burst.push_back(byte_item(($urandom_range(1) != 0) ? tracker.end_a : tracker.end_b));
            repeat ($urandom_range(0, 4))
            begin
                burst.push_back(read_item(($urandom_range(1) != 0) ?
                                          IDX_W'($urandom_range(0, 7)) : IDX_W'($urandom)));
            end
            if ($urandom_range(99) < 20)
            begin
                burst.push_back(byte_item(BYTE_W'($urandom)));
            end
            if ($urandom_range(99) < 85)
            begin
                burst.push_back(release_item());
            end
        end
    endfunction

    // valid stays high between back-to-back transactions
    task automatic drive_item(input item_t it);
        while (idling_on && $urandom_range(99) < 18)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        rx_item <= it;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        tracker.note_item(it);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (tracker.due.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        tracker.write_reg(idx, val);
    endtask

    // character registers get junk in the unused upper bits
    task automatic program_regs(input logic [BYTE_W-1:0] sync_c, input logic [BYTE_W-1:0] sep_c,
                                input logic [BYTE_W-1:0] end_a, input logic [BYTE_W-1:0] end_b,
                                input logic [TMO_W-1:0] rx_limit,
                                input logic [TMO_W-1:0] link_limit);
        write_reg(REG_SYNC_CHAR, {8'($urandom), sync_c});
        write_reg(REG_SEP_CHAR, {8'($urandom), sep_c});
        write_reg(REG_END_CHAR_A, {8'($urandom), end_a});
        write_reg(REG_END_CHAR_B, {8'($urandom), end_b});
        write_reg(REG_RX_TIMEOUT, rx_limit);
        write_reg(REG_LINK_TIMEOUT, link_limit);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_traffic(input int n_items, input bit pause_midway);
        int sent;
        bit paused;
        sent = 0;
        paused = 0;
        while (sent < n_items)
        begin
            burst.delete();
            build_burst();
            foreach (burst[i])
            begin
                drive_item(burst[i]);
            end
            sent += burst.size();
            if (pause_midway && !paused && sent >= n_items / 2)
            begin
                drain();
                paused = 1;
            end
        end
    endtask

    initial
    begin
        tracker = new();
        rst_n = 1'b0;
        item_valid = 1'b0;
        rx_item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idling_on = 1'b1;
        hold_off = 0;
        stuck_cycles = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset-value framing: restart, checksummed frame on the second end char, held-frame reject
        drive_item(read_item(5'd0));
        drive_item(byte_item(8'h24));
        drive_item(byte_item(8'h00));
        drive_item(byte_item(8'hFF));
        drive_item(byte_item(8'h24));
        drive_item(byte_item(8'h41));
        drive_item(byte_item(8'h62));
        drive_item(byte_item(8'h2A));
        drive_item(byte_item(8'h32));
        drive_item(byte_item(8'h33));
        drive_item(byte_item(8'h0A));
        drive_item(byte_item(8'h55));
        drive_item(read_item(5'd1));
        drive_item(read_item(5'd31));
        drive_item(release_item());
        drain();

        // short timeouts: bad checksum via sync and non-hex digits, timeout, link loss
        program_regs(8'h24, 8'h2A, 8'h0D, 8'h0A, 16'd2, 16'd3);
        drive_item(byte_item(8'h24));
        drive_item(byte_item(8'h51));
        drive_item(byte_item(8'h2A));
        drive_item(byte_item(8'h24));
        drive_item(byte_item(8'h67));
        drive_item(byte_item(8'h0D));
        drive_item(byte_item(8'h24));
        repeat (5) drive_item(tick_item());
        drive_item(byte_item(8'h24));
        drive_item(byte_item(8'h0D));
        repeat (4) drive_item(tick_item());
        drive_item(release_item());
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            idling_on = (ph != 3);
            case (ph)
                0: program_regs(8'h00, 8'hFF, 8'h0D, 8'h0A, 16'd1, 16'hFFFF);
                1: program_regs(8'h24, 8'h2A, 8'h00, 8'hFF, 16'hFFFF, 16'd1);
                2: program_regs(8'hFF, 8'h00, 8'h0D, 8'h0A, 16'($urandom_range(1, 12)),
                                16'($urandom_range(2, 40)));
                default: program_regs(pick_char(8'h24), pick_char(8'h2A), pick_char(8'h0D),
                                      pick_char(8'h0A), 16'($urandom_range(1, 12)),
                                      16'($urandom_range(2, 40)));
            endcase
            if (ph == 4)
            begin
                hold_off = 400;
            end
            run_traffic(200, ph == 1);
            drain();
        end
        repeat (8) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.due.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
